// File: rtl/text_console_writer_core_defines.svh
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'd7;

    typedef struct packed {
        logic [CHAR_W-1:0] attr;
        logic [CHAR_W-1:0] chr;
    } cell_t;

    localparam cell_t BLANK_CELL = '{attr: 8'd0, chr: CHAR_SPACE};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_PUT,
        ST_DONE
    } state_t;

endpackage

// File: rtl/text_console_writer_core.sv
// Text console of COLS x ROWS character cells (character low byte, attribute
// high byte) held in one single-port-read, single-port-write RAM, with a
// cursor. After reset the RAM is swept to blank cells before s_tready rises.
// A read or put item passes through accept, RAM access and result load,
// and the block takes no new item until its result is loaded; a zero byte
// skips the RAM access. Output back-pressure holds the block in the result
// load. A printable character or newline that meets a pending scroll first
// walks the RAM, copying every row up one through the RAM's read and write
// ports one cell a cycle and then blanking the bottom row.
// A result is always produced, also for a zero byte; a read reports the cell
// (zero when out of range) and every result reports the cursor after the item.
`include "text_console_writer_core_defines.svh"

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  cfg_wr_en,
    input  logic [CHAR_W-1:0]                                     cfg_wr_data,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // char_code, read_row, read_col, zero pad
    input  logic [((CHAR_W+$clog2(ROWS+1)+$clog2(COLS)+7)/8)*8-1:0] s_tdata,
    // opcode: 0 put, 1 read
    input  logic                                                  s_tuser,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // cell_char, cell_attribute, cursor_col, cursor_row, zero pad
    output logic [((2*CHAR_W+$clog2(COLS)+$clog2(ROWS+1)+7)/8)*8-1:0] m_tdata
);

    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS+1);
    localparam int CELLS  = COLS*ROWS;
    localparam int COPY_N = COLS*(ROWS-1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SWP_W  = $clog2(CELLS+1);
    localparam int OUT_TW = ((2*CHAR_W+COL_W+ROW_W+7)/8)*8;

    state_t              state_reg, state_next;
    logic [SWP_W-1:0]    sweep_reg, sweep_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [CHAR_W-1:0]   attr_reg;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [CHAR_W-1:0]   cell_char_reg, cell_char_next;
    logic [CHAR_W-1:0]   cell_attr_reg, cell_attr_next;
    logic                m_tvalid_reg;
    logic [OUT_TW-1:0]   m_data_reg;
    logic                load_out;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    cell_t               mem_wr_data;
    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr;
    cell_t               mem_rd_data;

    logic [CHAR_W-1:0]   in_char;
    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    in_col;
    logic                in_ok;
    logic [ADDR_W-1:0]   in_addr;
    logic [ADDR_W-1:0]   cur_addr;

    assign in_char  = s_tdata[CHAR_W-1:0];
    assign in_row   = s_tdata[CHAR_W +: ROW_W];
    assign in_col   = s_tdata[CHAR_W+ROW_W +: COL_W];
    assign in_ok    = (int'(in_row) < ROWS) && (int'(in_col) < COLS);
    assign in_addr  = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(COLS) + ADDR_W'(in_col));
    assign cur_addr = ADDR_W'(ADDR_W'(cur_row_reg) * ADDR_W'(COLS) + ADDR_W'(cur_col_reg));

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            sweep_reg    <= '0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            attr_reg     <= ATTR_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        rd_ok_reg     <= rd_ok_next;
        cell_char_reg <= cell_char_next;
        cell_attr_reg <= cell_attr_next;
        if (load_out)
        begin
            m_data_reg <= OUT_TW'({cur_row_reg, cur_col_reg, cell_attr_reg, cell_char_reg});
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        ch_next        = ch_reg;
        rd_ok_next     = rd_ok_reg;
        cell_char_next = cell_char_reg;
        cell_attr_next = cell_attr_reg;
        s_tready       = 1'b0;
        load_out       = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = BLANK_CELL;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ADDR_W'(sweep_reg);
                if (sweep_reg == SWP_W'(CELLS-1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ch_next        = in_char;
                    cell_char_next = '0;
                    cell_attr_next = '0;
                    if (s_tuser)
                    begin
                        rd_ok_next  = in_ok;
                        mem_rd_en   = in_ok;
                        mem_rd_addr = in_addr;
                        state_next  = ST_READ;
                    end
                    else if (in_char == CHAR_NUL)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (cur_row_reg == ROW_W'(ROWS))
                    begin
                        sweep_next = '0;
                        state_next = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_ok_reg)
                begin
                    cell_char_next = mem_rd_data.chr;
                    cell_attr_next = mem_rd_data.attr;
                end
                state_next = ST_DONE;
            end
            ST_COPY:
            begin
                // read one row ahead, write back what the previous cycle read
                if (sweep_reg != SWP_W'(COPY_N))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ADDR_W'(ADDR_W'(sweep_reg) + ADDR_W'(COLS));
                end
                if (sweep_reg != '0)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = ADDR_W'(sweep_reg - 1'b1);
                    mem_wr_data = mem_rd_data;
                end
                if (sweep_reg == SWP_W'(COPY_N))
                begin
                    sweep_next = '0;
                    state_next = ST_BLANK;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_BLANK:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ADDR_W'(ADDR_W'(COPY_N) + ADDR_W'(sweep_reg));
                if (sweep_reg == SWP_W'(COLS-1))
                begin
                    sweep_next   = '0;
                    cur_row_next = ROW_W'(ROWS-1);
                    state_next   = ST_PUT;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_PUT:
            begin
                if (ch_reg == CHAR_NEWLINE)
                begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + 1'b1;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cur_addr;
                    mem_wr_data = '{attr: attr_reg, chr: ch_reg};
                    if (int'(cur_col_reg) == COLS-1)
                    begin
                        cur_col_next = '0;
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg + 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    `TCW_ASSERT_NOW(a_row_range, 1'b1, int'(cur_row_reg) <= ROWS,
        "cursor row beyond the pending-scroll row")
    `TCW_ASSERT_NOW(a_col_range, 1'b1, int'(cur_col_reg) < COLS,
        "cursor column beyond the last column")
    `TCW_ASSERT_NEXT(a_scroll_start,
        s_tvalid && s_tready && !s_tuser && (in_char != CHAR_NUL)
            && (cur_row_reg == ROW_W'(ROWS)),
        state_reg == ST_COPY,
        "pending scroll not started by a printable item")
    `TCW_ASSERT_NOW(a_copy_bounds, (state_reg == ST_COPY) && mem_wr_en,
        int'(mem_wr_addr) < COPY_N,
        "row copy writes into the bottom row")
    `TCW_ASSERT_NOW(a_result_source, $rose(m_tvalid_reg),
        $past(state_reg) == ST_DONE,
        "result raised outside the completion state")

endmodule

// File: rtl/tcw_screen_ram.sv
module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  cell_t             wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output cell_t             rd_data
);

    cell_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: bench/tb_text_console_writer_core.sv
localparam int SCREEN_COLS = 80;
localparam int SCREEN_ROWS = 25;
localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

typedef enum bit {
    OP_PUT,
    OP_READ
} console_op_t;

typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] attr;
    logic [7:0] chr;
} console_view_t;

class screen_mirror;
    tcw_pkg::cell_t cells [SCREEN_CELLS];
    int cur_col;
    int cur_row;
    logic [7:0] attribute;
    console_view_t awaited_views [$];
    int mismatches;

    function new();
        for (int i = 0; i < SCREEN_CELLS; i++)
            cells[i] = tcw_pkg::BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
        attribute = tcw_pkg::ATTR_RESET;
        mismatches = 0;
    endfunction

    function void scroll_up();
        for (int i = 0; i < SCREEN_COLS * (SCREEN_ROWS - 1); i++)
            cells[i] = cells[i + SCREEN_COLS];
        for (int i = SCREEN_COLS * (SCREEN_ROWS - 1); i < SCREEN_CELLS; i++)
            cells[i] = tcw_pkg::BLANK_CELL;
        cur_row = SCREEN_ROWS - 1;
    endfunction

    function void put_char(logic [7:0] ch);
        if (ch == tcw_pkg::CHAR_NUL)
            return;
        // a pending scroll is carried out only by a newline or a printable byte
        if (cur_row >= SCREEN_ROWS)
            scroll_up();
        if (ch == tcw_pkg::CHAR_NEWLINE)
        begin
            cur_col = 0;
            cur_row++;
            return;
        end
        cells[cur_row * SCREEN_COLS + cur_col] = '{attr: attribute, chr: ch};
        cur_col++;
        if (cur_col >= SCREEN_COLS)
        begin
            cur_col = 0;
            cur_row++;
        end
    endfunction

    function void note_item(console_op_t op, logic [7:0] ch, logic [4:0] rrow,
                            logic [6:0] rcol);
        console_view_t view;
        tcw_pkg::cell_t c;
        view = '0;
        if (op == OP_PUT)
            put_char(ch);
        else if (int'(rrow) < SCREEN_ROWS && int'(rcol) < SCREEN_COLS)
        begin
            c = cells[int'(rrow) * SCREEN_COLS + int'(rcol)];
            view.chr = c.chr;
            view.attr = c.attr;
        end
        view.col = cur_col[6:0];
        view.row = cur_row[4:0];
        awaited_views.push_back(view);
    endfunction

    task report(string what, longint got, longint want);
        mismatches++;
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_result(logic [31:0] data);
        console_view_t want;
        if (awaited_views.size() == 0)
        begin
            report("result with nothing awaited", data, 0);
            return;
        end
        want = awaited_views.pop_front();
        if (data[7:0] !== want.chr)
            report("cell_char", data[7:0], want.chr);
        if (data[15:8] !== want.attr)
            report("cell_attribute", data[15:8], want.attr);
        if (data[22:16] !== want.col)
            report("cursor_col", data[22:16], want.col);
        if (data[27:23] !== want.row)
            report("cursor_row", data[27:23], want.row);
    endtask
endclass

module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // char_code, read_row, read_col, zero pad
    logic [23:0] s_tdata = '0;
    // opcode
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // cell_char, cell_attribute, cursor_col, cursor_row, zero pad
    logic [31:0] m_tdata;

    screen_mirror mirror = new();
    int idle_cycles = 0;
    int hold_cycles = 0;
    bit sender_quiet = 1'b0;
    bit receiver_quiet = 1'b0;

    always #6 clk = ~clk;

    text_console_writer_core #(
        .COLS(SCREEN_COLS),
        .ROWS(SCREEN_ROWS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    task automatic send_item(console_op_t op, logic [7:0] ch, logic [4:0] rrow,
                             logic [6:0] rcol);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser = op;
        s_tdata = {4'b0, rcol, rrow, ch};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        mirror.note_item(op, ch, rrow, rcol);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (mirror.awaited_views.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic set_attribute(logic [7:0] value);
        cfg_wr_data = value;
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        mirror.attribute = value;
    endtask

    task automatic send_random(int count);
        int k;
        int pick;
        int base;
        logic [7:0] ch;
        logic [4:0] rr;
        logic [6:0] rc;
        k = 0;
        while (k < count)
        begin
            if (k % 100 == 0)
            begin
                sender_quiet = ($urandom_range(0, 3) == 0);
                receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            ch = 8'($urandom);
            rr = 5'($urandom);
            rc = 7'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                // run of newlines to reach the bottom and force a scroll
                repeat ($urandom_range(20, 30))
                begin
                    rr = 5'($urandom);
                    rc = 7'($urandom);
                    send_item(OP_PUT, CHAR_NEWLINE, rr, rc);
                    k++;
                end
            end
            else if (pick < 45)
            begin
                ch = 8'($urandom_range(1, 255));
                send_item(OP_PUT, ch, rr, rc);
                k++;
            end
            else if (pick < 58)
            begin
                send_item(OP_PUT, CHAR_NEWLINE, rr, rc);
                k++;
            end
            else if (pick < 64)
            begin
                send_item(OP_PUT, CHAR_NUL, rr, rc);
                k++;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:
                    begin
                        // aim at the lines being written
                        base = (mirror.cur_row > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1
                                                                  : mirror.cur_row;
                        if (base > 0)
                            base = base - $urandom_range(0, 1);
                        rr = 5'(base);
                        rc = 7'($urandom_range(0, SCREEN_COLS - 1));
                    end
                    2, 3:
                    begin
                        rr = 5'($urandom_range(0, SCREEN_ROWS - 1));
                        rc = 7'($urandom_range(0, SCREEN_COLS - 1));
                    end
                    default: ;
                endcase
                send_item(OP_READ, ch, rr, rc);
                k++;
            end
        end
    endtask

    initial
    begin : sink
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = receiver_quiet ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("text_console_writer_core verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        logic [7:0] attrs [6];
        attrs[0] = 8'h00;
        attrs[1] = 8'hFF;
        attrs[2] = 8'($urandom);
        attrs[3] = 8'h80;
        attrs[4] = 8'($urandom);
        attrs[5] = 8'h01;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        while (!s_tready)
            @(negedge clk);

        // reset attribute still in force here
        send_item(OP_READ, 8'h00, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h01, 5'h1F, 7'h7F);
        send_item(OP_PUT, 8'hFF, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h41, 5'h15, 7'h2A);
        send_item(OP_PUT, CHAR_NUL, 5'h0A, 7'h55);
        send_item(OP_PUT, CHAR_NEWLINE, 5'h1F, 7'h7F);
        send_item(OP_PUT, CHAR_SPACE, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h80, 5'd3, 7'd3);
        send_item(OP_READ, 8'hFF, 5'd0, 7'd0);
        send_item(OP_READ, 8'h00, 5'd0, 7'd1);
        send_item(OP_READ, 8'hAA, 5'd0, 7'd2);
        send_item(OP_READ, 8'h55, 5'd0, 7'd3);
        send_item(OP_READ, 8'hFF, 5'd1, 7'd0);
        send_item(OP_READ, 8'h00, 5'd1, 7'd1);
        send_item(OP_READ, 8'h00, 5'd24, 7'd79);
        send_item(OP_READ, 8'h00, 5'd25, 7'd0);
        send_item(OP_READ, 8'hFF, 5'h1F, 7'h7F);
        send_item(OP_READ, 8'h00, 5'd0, 7'd80);
        send_item(OP_READ, 8'h00, 5'd24, 7'h7F);
        send_item(OP_READ, 8'h00, 5'h1F, 7'd0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            set_attribute(attrs[p]);
            if (p == 0)
            begin
                send_random(40);
                // stall the sink for a long stretch while items keep coming
                hold_cycles = 400;
                send_random(240);
            end
            else if (p == 2)
            begin
                send_random(140);
                drain();
                send_random(140);
            end
            else
                send_random(280);
            drain();
        end

        repeat (10) @(negedge clk);
        if (mirror.mismatches == 0 && mirror.awaited_views.size() == 0)
            $display("text_console_writer_core verification clean");
        else
            $display("text_console_writer_core verification failed");
        $finish;
    end
endmodule
